// File: hdl/air_quality_led_beep_indicator_defines.svh
// Assertion macros used by the checker file of the indicator block.
`ifndef AIR_QUALITY_LED_BEEP_INDICATOR_DEFINES_SVH
`define AIR_QUALITY_LED_BEEP_INDICATOR_DEFINES_SVH

// Clocked assertion, held off while reset is asserted.
`define AQI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Assertion that applies only while a result is offered.
`define AQI_ASSERT_RESULT(lbl, prop, msg) \
  `AQI_ASSERT(lbl, out_valid |-> (prop), msg)

`endif

// File: hdl/aqi_pkg.sv
package aqi_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_LED_MODE         = 3'd0;
  localparam cfg_idx_t CFG_BEEP_ENABLE      = 3'd1;
  localparam cfg_idx_t CFG_BLINK_PERIOD     = 3'd2;
  localparam cfg_idx_t CFG_LIT_THRESHOLD    = 3'd3;
  localparam cfg_idx_t CFG_BEEP_DELAY       = 3'd4;
  localparam cfg_idx_t CFG_TICKS_PER_SECOND = 3'd5;

  localparam logic [1:0] LED_MODE_OFF    = 2'd1;
  localparam logic [1:0] LED_MODE_STEADY = 2'd2;

  localparam logic [1:0] LEVEL_NORMAL = 2'd0;
  localparam logic [1:0] LEVEL_MILD   = 2'd1;

  localparam logic [15:0] BLINK_PERIOD_RST     = 16'd100;
  localparam logic [15:0] LIT_THRESHOLD_RST    = 16'd99;
  localparam logic [15:0] BEEP_DELAY_RST       = 16'd300;
  localparam logic [7:0]  TICKS_PER_SECOND_RST = 8'd10;

endpackage

// File: hdl/air_quality_led_beep_indicator.sv
// A result is registered and offered in the cycle after its tick transfer.
// Throughput: one tick per cycle unless a held result stalls the input; the
// next counter values and compares are combinational up to the result register.
// Reset (synchronous, active low): all counters and the buzzer clear, the
// registers take their defaults, and no result is offered.
module air_quality_led_beep_indicator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_air_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_green_lit,
  output logic                 out_orange_lit,
  output logic                 out_red_lit,
  output logic                 out_buzzer_on,
  output logic                 out_wake_request,
  output logic                 out_sleep_request,
  output logic [31:0]          out_seconds_now,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  aqi_pkg::cfg_idx_t    cfg_index,
  input  aqi_pkg::cfg_data_t   cfg_data
);
  import aqi_pkg::*;

  logic [1:0]  led_mode_r;
  logic        beep_enable_r;
  logic [15:0] blink_period_r;
  logic [15:0] lit_threshold_r;
  logic [15:0] beep_delay_r;
  logic [7:0]  ticks_per_second_r;

  logic [7:0]  sub_r, sub_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [15:0] blink_r, blink_nxt;
  logic [15:0] beep_r, beep_nxt;
  logic        buzz_r, buzz_nxt;
  logic        wake_nxt, sleep_nxt;
  logic        lit;
  logic [15:0] d1, d2, d3;

  logic        out_valid_r;
  logic        green_r, orange_r, red_r, buzz_out_r, wake_r, sleep_r;
  logic [31:0] sec_out_r;
  logic        in_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;

  assign d1 = beep_delay_r + 16'd1;
  assign d2 = beep_delay_r + 16'd2;
  assign d3 = beep_delay_r + 16'd3;

  always_comb begin
    sub_nxt = sub_r + 8'd1;
    sec_nxt = sec_r;
    if (sub_nxt >= ticks_per_second_r) begin
      sub_nxt = '0;
      sec_nxt = sec_r + 32'd1;
    end

    // The blink counter runs in every mode but only wraps in blink mode.
    blink_nxt = blink_r + 16'd1;
    if (led_mode_r == LED_MODE_OFF) begin
      lit = 1'b0;
    end else if (led_mode_r == LED_MODE_STEADY) begin
      lit = 1'b1;
    end else begin
      if (blink_nxt >= blink_period_r) blink_nxt = '0;
      lit = blink_nxt >= lit_threshold_r;
    end

    beep_nxt  = beep_r;
    buzz_nxt  = buzz_r;
    wake_nxt  = 1'b0;
    sleep_nxt = 1'b0;
    if (beep_enable_r) begin
      if (in_air_level == LEVEL_NORMAL) begin
        beep_nxt = '0;
        buzz_nxt = 1'b0;
      end else begin
        beep_nxt = beep_r + 16'd1;
        if (beep_nxt == beep_delay_r) begin
          buzz_nxt = 1'b1;
          wake_nxt = 1'b1;
        end else if (beep_nxt == d1) begin
          buzz_nxt = 1'b0;
          // A mild level ends its pattern after the single beep.
          if (in_air_level == LEVEL_MILD) begin
            beep_nxt  = '0;
            sleep_nxt = 1'b1;
          end
        end else if (in_air_level != LEVEL_MILD && beep_nxt == d2) begin
          buzz_nxt = 1'b1;
        end else if (in_air_level != LEVEL_MILD && beep_nxt == d3) begin
          beep_nxt  = '0;
          buzz_nxt  = 1'b0;
          sleep_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_mode_r         <= '0;
      beep_enable_r      <= 1'b0;
      blink_period_r     <= BLINK_PERIOD_RST;
      lit_threshold_r    <= LIT_THRESHOLD_RST;
      beep_delay_r       <= BEEP_DELAY_RST;
      ticks_per_second_r <= TICKS_PER_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LED_MODE:         led_mode_r         <= cfg_data[1:0];
        CFG_BEEP_ENABLE:      beep_enable_r      <= cfg_data[0];
        CFG_BLINK_PERIOD:     blink_period_r     <= cfg_data;
        CFG_LIT_THRESHOLD:    lit_threshold_r    <= cfg_data;
        CFG_BEEP_DELAY:       beep_delay_r       <= cfg_data;
        CFG_TICKS_PER_SECOND: ticks_per_second_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      sec_r       <= '0;
      blink_r     <= '0;
      beep_r      <= '0;
      buzz_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        sub_r   <= sub_nxt;
        sec_r   <= sec_nxt;
        blink_r <= blink_nxt;
        beep_r  <= beep_nxt;
        buzz_r  <= buzz_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      green_r    <= lit && (in_air_level == LEVEL_NORMAL);
      orange_r   <= lit && (in_air_level == LEVEL_MILD);
      red_r      <= lit && in_air_level[1];
      buzz_out_r <= buzz_nxt;
      wake_r     <= wake_nxt;
      sleep_r    <= sleep_nxt;
      sec_out_r  <= sec_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_green_lit     = green_r;
  assign out_orange_lit    = orange_r;
  assign out_red_lit       = red_r;
  assign out_buzzer_on     = buzz_out_r;
  assign out_wake_request  = wake_r;
  assign out_sleep_request = sleep_r;
  assign out_seconds_now   = sec_out_r;

endmodule

// File: hdl/aqi_checker.sv
`include "air_quality_led_beep_indicator_defines.svh"

module aqi_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_green_lit,
  input logic out_orange_lit,
  input logic out_red_lit,
  input logic out_buzzer_on,
  input logic out_wake_request,
  input logic out_sleep_request
);
  logic [2:0] led_bits;

  assign led_bits = {out_green_lit, out_orange_lit, out_red_lit};

  // A held result must also hold back the next tick.
  `AQI_ASSERT(a_stall_back, (out_valid && out_stall) |-> in_stall, "tick taken over held result")
  `AQI_ASSERT(a_out_holds, (out_valid && out_stall) |=> out_valid, "held result dropped")
  `AQI_ASSERT_RESULT(a_one_led, $countones(led_bits) <= 1, "more than one LED lit")
  `AQI_ASSERT_RESULT(a_wake_on, out_wake_request |-> out_buzzer_on, "wake without buzzer on")
  `AQI_ASSERT_RESULT(a_sleep_off, out_sleep_request |-> !out_buzzer_on, "sleep with buzzer on")

endmodule

bind air_quality_led_beep_indicator aqi_checker u_aqi_checker (.*);
